>>> rtl/sss_pkg.sv
// package: widths, codes and result type for the sample series block
package sss_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int IDX_W = 6;
    localparam int COUNT_W = 7;
    localparam int VAR_W = 63;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LSEARCH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEDUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SORT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BSEARCH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0] found_index;
        logic [COUNT_W-1:0] sample_count;
        logic signed [DATA_W-1:0] mean;
        logic [VAR_W-1:0] variance;
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] maximum;
        logic [DATA_W-1:0] span;
    } out_word_t;

endpackage

>>> rtl/sss_if.sv
// valid/ready channel interfaces for input and result words
interface sss_in_if;
    import sss_pkg::*;
    logic valid;
    logic ready;
    logic [MODE_W-1:0] mode;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface sss_out_if;
    import sss_pkg::*;
    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0] found_index;
    logic [COUNT_W-1:0] sample_count;
    logic signed [DATA_W-1:0] mean;
    logic [VAR_W-1:0] variance;
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic [DATA_W-1:0] span;
    modport source (output valid, output status, output found_index, output sample_count,
                    output mean, output variance, output minimum, output maximum,
                    output span, input ready);
    modport sink (input valid, input status, input found_index, input sample_count,
                  input mean, input variance, input minimum, input maximum,
                  input span, output ready);
endinterface

>>> rtl/sample_series_stats_search.sv
// Sample series statistics and search block.
// Input channel in_ch carries mode and value words; result channel out_ch
// carries one result word per accepted input word.
// One word is worked at a time. in_ch.ready is high only while idle.
// Work per mode, with n samples held:
//   unused modes and empty series: straight to the result; append: one store write
//   linear search: one sample store read per probe
//   binary search: one sorted store read per probe
//   statistics: a sum pass, a mean divide, a variance pass with
//     one 33x33 multiply per sample, then a variance divide
//   dedup: one store read per compare
//   sort: insertion sort over the sorted store
// All sequencing runs through the single read/write port of each memory.
// Reset clears both counts; memories are not cleared and results use only
// entries below the held counts. A finished result sits in the output register
// until taken; a stalled receiver holds the block but loses nothing.
module sample_series_stats_search #(
    parameter int DEPTH = sss_pkg::DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    sss_in_if.sink in_ch,
    sss_out_if.source out_ch
);
    import sss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SUM_W = DATA_W + CW + 1;
    localparam int ACC_W = 2 * DATA_W + 2 + CW;
    localparam int QNUM_W = ACC_W;

    typedef enum logic [4:0] {
        S_IDLE, S_APPEND, S_SUM_RD, S_SUM_AC, S_MEAN_GO, S_MEAN_WT, S_VAR_RD, S_VAR_SQ,
        S_VAR_MUL, S_VAR_AC, S_VAR_GO, S_VAR_WT, S_LS_RD, S_LS_CK, S_DD_RDI, S_DD_RDJ,
        S_DD_CK, S_SO_RDI, S_SO_RDJ, S_SO_CK, S_SO_PUT, S_BS_RD, S_BS_CK,
        S_BS_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] sorted_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] kept_reg;
    logic [CW-1:0] hi_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [DATA_W-1:0] mn_reg;
    logic signed [DATA_W-1:0] mx_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [DATA_W:0] absd_reg;
    logic [2*DATA_W+1:0] sq_reg;
    logic [ACC_W-1:0] acc_reg;
    out_word_t res_reg;
    logic out_valid_reg;

    logic sa_we;
    logic [AW-1:0] sa_addr;
    logic [DATA_W-1:0] sa_wdata;
    logic [DATA_W-1:0] sa_rdata;
    logic so_we;
    logic [AW-1:0] so_addr;
    logic [DATA_W-1:0] so_wdata;
    logic [DATA_W-1:0] so_rdata;

    logic div_start;
    logic [QNUM_W-1:0] div_num;
    logic div_done;
    logic [QNUM_W-1:0] div_quot;

    logic [CW-1:0] mid;
    logic signed [DATA_W-1:0] sa_s;
    logic signed [DATA_W-1:0] so_s;
    logic sum_neg;
    logic [SUM_W-1:0] sum_abs;
    logic signed [DATA_W+1:0] diff;

    assign sa_s = sa_rdata;
    assign so_s = so_rdata;
    assign mid = i_reg + ((hi_reg - i_reg) >> 1);
    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_abs = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign diff = {{2{sa_s[DATA_W-1]}}, sa_s} - {{2{mean_reg[DATA_W-1]}}, mean_reg};

    sss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_samples (
        .clk(clk), .we(sa_we), .addr(sa_addr), .wdata(sa_wdata), .rdata(sa_rdata)
    );
    sss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_sorted (
        .clk(clk), .we(so_we), .addr(so_addr), .wdata(so_wdata), .rdata(so_rdata)
    );
    sss_div #(.NUM_W(QNUM_W), .DEN_W(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(held_reg),
        .done(div_done), .quot(div_quot)
    );

    // memory port and divider control
    always_comb
    begin
        sa_we = 1'b0;
        sa_addr = i_reg[AW-1:0];
        sa_wdata = x_reg;
        so_we = 1'b0;
        so_addr = j_reg[AW-1:0];
        so_wdata = x_reg;
        div_start = 1'b0;
        div_num = QNUM_W'(sum_abs);
        unique case (state_reg)
            S_APPEND:
            begin
                sa_we = (held_reg < CW'(DEPTH));
                sa_addr = held_reg[AW-1:0];
                sa_wdata = key_reg;
            end
            S_DD_RDJ: sa_addr = j_reg[AW-1:0];
            S_DD_CK:
            begin
                sa_we = (j_reg == kept_reg);
                sa_addr = kept_reg[AW-1:0];
            end
            S_SO_RDJ: so_addr = j_reg[AW-1:0] - 1'b1;
            S_SO_CK:
            begin
                so_we = (j_reg != '0) && (so_s > x_reg);
                so_addr = j_reg[AW-1:0];
                so_wdata = so_rdata;
            end
            S_SO_PUT: so_we = 1'b1;
            S_BS_RD: so_addr = mid[AW-1:0];
            S_BS_FIN: so_addr = i_reg[AW-1:0];
            S_MEAN_GO: div_start = 1'b1;
            S_VAR_GO:
            begin
                div_start = 1'b1;
                div_num = acc_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;
            sorted_reg <= '0;
            res_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        key_reg <= in_ch.value;
                        i_reg <= '0;
                        j_reg <= '0;
                        kept_reg <= '0;
                        sum_reg <= '0;
                        acc_reg <= '0;
                        hi_reg <= sorted_reg;
                        priority case (in_ch.mode)
                            MODE_APPEND: state_reg <= S_APPEND;
                            MODE_STATS:
                            begin
                                if (held_reg == '0)
                                begin
                                    res_reg.status <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_SUM_RD;
                                end
                            end
                            MODE_LSEARCH:
                            begin
                                if (held_reg == '0)
                                begin
                                    res_reg.status <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_LS_RD;
                                end
                            end
                            MODE_DEDUP:
                            begin
                                if (held_reg == '0)
                                begin
                                    res_reg.status <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_DD_RDI;
                                end
                            end
                            MODE_SORT:
                            begin
                                sorted_reg <= held_reg;
                                if (held_reg == '0)
                                begin
                                    res_reg.status <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_SO_RDI;
                                end
                            end
                            MODE_BSEARCH:
                            begin
                                if (sorted_reg == '0)
                                begin
                                    res_reg.status <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_BS_RD;
                                end
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_APPEND:
                begin
                    if (held_reg < CW'(DEPTH))
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                    else
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    state_reg <= S_OUT;
                end
                // statistics: sum, min, max
                S_SUM_RD: state_reg <= S_SUM_AC;
                S_SUM_AC:
                begin
                    sum_reg <= sum_reg + SUM_W'(sa_s);
                    if (i_reg == '0 || sa_s < mn_reg)
                    begin
                        mn_reg <= sa_s;
                    end
                    if (i_reg == '0 || sa_s > mx_reg)
                    begin
                        mx_reg <= sa_s;
                    end
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == held_reg) ? S_MEAN_GO : S_SUM_RD;
                end
                S_MEAN_GO: state_reg <= S_MEAN_WT;
                S_MEAN_WT:
                begin
                    if (div_done)
                    begin
                        mean_reg <= sum_neg ? DATA_W'(-div_quot[DATA_W-1:0])
                                            : div_quot[DATA_W-1:0];
                        i_reg <= '0;
                        state_reg <= S_VAR_RD;
                    end
                end
                S_VAR_RD: state_reg <= S_VAR_SQ;
                S_VAR_SQ:
                begin
                    absd_reg <= diff[DATA_W+1] ? (DATA_W+1)'(-diff) : diff[DATA_W:0];
                    state_reg <= S_VAR_MUL;
                end
                S_VAR_MUL: state_reg <= S_VAR_AC;
                S_VAR_AC:
                begin
                    acc_reg <= acc_reg + ACC_W'(sq_reg);
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == held_reg) ? S_VAR_GO : S_VAR_RD;
                end
                S_VAR_GO: state_reg <= S_VAR_WT;
                S_VAR_WT:
                begin
                    if (div_done)
                    begin
                        res_reg.mean <= mean_reg;
                        res_reg.minimum <= mn_reg;
                        res_reg.maximum <= mx_reg;
                        res_reg.span <= DATA_W'(mx_reg - mn_reg);
                        res_reg.variance <= (div_quot[QNUM_W-1:VAR_W] != '0)
                            ? {VAR_W{1'b1}} : div_quot[VAR_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                // linear search
                S_LS_RD: state_reg <= S_LS_CK;
                S_LS_CK:
                begin
                    if (sa_s == key_reg)
                    begin
                        res_reg.found_index <= IDX_W'(i_reg);
                        state_reg <= S_OUT;
                    end
                    else if (i_reg + 1'b1 == held_reg)
                    begin
                        res_reg.status <= ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_LS_RD;
                    end
                end
                // dedup: x = sample[i], compare with sample[0..kept-1]
                S_DD_RDI:
                begin
                    j_reg <= '0;
                    state_reg <= S_DD_RDJ;
                end
                S_DD_RDJ:
                begin
                    if (j_reg == '0)
                    begin
                        x_reg <= sa_s;
                    end
                    state_reg <= (j_reg == kept_reg) ? S_DD_CK : S_DD_CK;
                end
                S_DD_CK:
                begin
                    if (j_reg == kept_reg)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                        if (i_reg + 1'b1 == held_reg)
                        begin
                            held_reg <= kept_reg + 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DD_RDI;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    else if (sa_s == x_reg)
                    begin
                        if (i_reg + 1'b1 == held_reg)
                        begin
                            held_reg <= kept_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DD_RDI;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_DD_RDJ;
                    end
                end
                // insertion sort into sorted store
                S_SO_RDI:
                begin
                    j_reg <= i_reg;
                    state_reg <= S_SO_RDJ;
                end
                S_SO_RDJ:
                begin
                    if (j_reg == i_reg)
                    begin
                        x_reg <= sa_s;
                    end
                    state_reg <= S_SO_CK;
                end
                S_SO_CK:
                begin
                    if (j_reg != '0 && so_s > x_reg)
                    begin
                        j_reg <= j_reg - 1'b1;
                        state_reg <= S_SO_RDJ;
                    end
                    else
                    begin
                        state_reg <= S_SO_PUT;
                    end
                end
                S_SO_PUT:
                begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= (i_reg + 1'b1 == held_reg) ? S_OUT : S_SO_RDI;
                end
                // lower-bound binary search, lo in i_reg
                S_BS_RD:
                begin
                    state_reg <= (i_reg < hi_reg) ? S_BS_CK : S_BS_FIN;
                    j_reg <= mid;
                end
                S_BS_CK:
                begin
                    if (so_s < key_reg)
                    begin
                        i_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= j_reg;
                    end
                    state_reg <= S_BS_RD;
                end
                S_BS_FIN:
                begin
                    j_reg <= '1;
                    if (j_reg == '1)
                    begin
                        if (i_reg < sorted_reg && so_s == key_reg)
                        begin
                            res_reg.found_index <= IDX_W'(i_reg);
                        end
                        else
                        begin
                            res_reg.status <= ST_NOTFOUND;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        res_reg <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (out_valid_reg && out_ch.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= absd_reg * absd_reg;
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    out_word_t show_reg;
    out_word_t show_next;
    always_comb
    begin
        show_next = res_reg;
        show_next.sample_count = COUNT_W'(held_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
        begin
            show_reg <= show_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = show_reg.status;
    assign out_ch.found_index = show_reg.found_index;
    assign out_ch.sample_count = show_reg.sample_count;
    assign out_ch.mean = show_reg.mean;
    assign out_ch.variance = show_reg.variance;
    assign out_ch.minimum = show_reg.minimum;
    assign out_ch.maximum = show_reg.maximum;
    assign out_ch.span = show_reg.span;
endmodule

>>> rtl/sss_ram.sv
// generic single-port synchronous ram with registered read
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/sss_div.sv
// restoring divider: unsigned dividend by unsigned divisor, one bit per cycle
module sss_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0] r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] shifted;

    assign shifted = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign trial = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
                q_reg <= num;
                r_reg <= '0;
                d_reg <= den;
            end
            else if (busy_reg)
            begin
                if (!trial[DEN_W])
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

>>> rtl/sss_checker.sv
// port-level checker for the sample series block, bound to the top level
module sss_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [sss_pkg::STATUS_W-1:0] out_status,
    input logic [sss_pkg::IDX_W-1:0] out_found_index,
    input logic [sss_pkg::DATA_W-1:0] out_span
);
    import sss_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
        else $error("stalled result changed");

    a_notfound_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ST_OK) |-> (out_found_index == '0 && out_span == '0))
        else $error("failed item carries data");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");
endmodule

bind sample_series_stats_search sss_checker u_sss_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_found_index(out_ch.found_index),
    .out_span(out_ch.span)
);

>>> tb/tb_sample_series_stats_search.sv
// testbench for the sample series block: directed and random mode words checked against a predictor
`timescale 1ns / 1ps
module tb_sample_series_stats_search;
    import sss_pkg::*;

    localparam int N = DEPTH_DEFAULT;

    logic clk;
    logic rst_n;
    sss_in_if in_ch();
    sss_out_if out_ch();

    sample_series_stats_search #(.DEPTH(N)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    logic signed [31:0] series_q [N];
    logic signed [31:0] sorted_q [N];
    int unsigned series_n;
    int unsigned sorted_n;
    out_word_t expected_words[$];
    int unsigned error_count;
    int unsigned result_count;
    bit rx_busy_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("FAIL sample_series_stats_search");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [62:0] series_variance(longint mean_v, int unsigned n);
        logic [127:0] acc;
        logic [127:0] q;
        longint d;
        logic [63:0] a;
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            d = longint'(series_q[i]) - mean_v;
            a = (d < 0) ? 64'(-d) : 64'(d);
            acc = acc + 128'(a * a);
        end
        q = acc / n;
        if (q > 128'h7FFF_FFFF_FFFF_FFFF)
            return 63'h7FFF_FFFF_FFFF_FFFF;
        return q[62:0];
    endfunction

    function automatic out_word_t predict_word(logic [2:0] mode, logic signed [31:0] v);
        out_word_t w;
        longint sum;
        longint mn;
        longint mx;
        longint mean_v;
        int unsigned kept;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int j;
        bit dup;
        logic signed [31:0] x;
        w = '0;
        w.status = ST_OK;
        case (mode)
            MODE_APPEND:
                if (series_n >= N)
                    w.status = ST_FULL;
                else
                begin
                    series_q[series_n] = v;
                    series_n++;
                end
            MODE_STATS:
                if (series_n == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    sum = 0;
                    mn = series_q[0];
                    mx = series_q[0];
                    for (int i = 0; i < series_n; i++)
                    begin
                        sum += series_q[i];
                        if (series_q[i] < mn) mn = series_q[i];
                        if (series_q[i] > mx) mx = series_q[i];
                    end
                    mean_v = sum / longint'(series_n);
                    w.mean = 32'(mean_v);
                    w.variance = series_variance(mean_v, series_n);
                    w.minimum = 32'(mn);
                    w.maximum = 32'(mx);
                    w.span = 32'(mx - mn);
                end
            MODE_LSEARCH:
                if (series_n == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    w.status = ST_NOTFOUND;
                    for (int i = 0; i < series_n; i++)
                        if (series_q[i] == v)
                        begin
                            w.status = ST_OK;
                            w.found_index = 6'(i);
                            break;
                        end
                end
            MODE_DEDUP:
                if (series_n == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    kept = 0;
                    for (int i = 0; i < series_n; i++)
                    begin
                        dup = 0;
                        for (int k = 0; k < kept; k++)
                            if (series_q[k] == series_q[i])
                                dup = 1;
                        if (!dup)
                        begin
                            series_q[kept] = series_q[i];
                            kept++;
                        end
                    end
                    series_n = kept;
                end
            MODE_SORT:
            begin
                for (int i = 0; i < series_n; i++)
                begin
                    x = series_q[i];
                    j = i;
                    while (j > 0 && sorted_q[j-1] > x)
                    begin
                        sorted_q[j] = sorted_q[j-1];
                        j--;
                    end
                    sorted_q[j] = x;
                end
                sorted_n = series_n;
                if (series_n == 0)
                    w.status = ST_EMPTY;
            end
            MODE_BSEARCH:
                if (sorted_n == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    lo = 0;
                    hi = sorted_n;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (sorted_q[mid] < v)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    if (lo < sorted_n && sorted_q[lo] == v)
                        w.found_index = 6'(lo);
                    else
                        w.status = ST_NOTFOUND;
                end
            default:
                ;
        endcase
        w.sample_count = 7'(series_n);
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, result_count);
        error_count++;
    endtask

    task automatic send_word(logic [2:0] mode, logic signed [31:0] v);
        repeat (gap_len()) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.mode = mode;
        in_ch.value = v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_words.push_back(predict_word(mode, v));
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed(32'($urandom_range(0, 7)) << 16);
            3: return $signed(32'($urandom_range(0, 15)));
            default: return $signed($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected result word", 64'(out_ch.status), 64'(0));
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(want.status));
                if (out_ch.found_index !== want.found_index)
                    report_mismatch("found_index", 64'(out_ch.found_index),
                                    64'(want.found_index));
                if (out_ch.sample_count !== want.sample_count)
                    report_mismatch("sample_count", 64'(out_ch.sample_count),
                                    64'(want.sample_count));
                if (out_ch.mean !== want.mean)
                    report_mismatch("mean", 64'(out_ch.mean), 64'(want.mean));
                if (out_ch.variance !== want.variance)
                    report_mismatch("variance", 64'(out_ch.variance), 64'(want.variance));
                if (out_ch.minimum !== want.minimum)
                    report_mismatch("minimum", 64'(out_ch.minimum), 64'(want.minimum));
                if (out_ch.maximum !== want.maximum)
                    report_mismatch("maximum", 64'(out_ch.maximum), 64'(want.maximum));
                if (out_ch.span !== want.span)
                    report_mismatch("span", 64'(out_ch.span), 64'(want.span));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_busy_mode)
            out_ch.ready <= ($urandom_range(0, 99) < 60);
        else
            out_ch.ready <= 1'b1;
    end

    always @(negedge clk)
        if ($urandom_range(0, 499) == 0)
            rx_busy_mode <= ~rx_busy_mode;

    task automatic test_empty();
        send_word(MODE_STATS, 0);
        send_word(MODE_LSEARCH, 0);
        send_word(MODE_DEDUP, 0);
        send_word(MODE_BSEARCH, 0);
        send_word(MODE_SORT, 0);
        send_word(3'd6, 32'sh7FFF_FFFF);
        send_word(3'd7, 32'sh8000_0000);
    endtask

    task automatic test_extremes();
        send_word(MODE_APPEND, 32'sh8000_0000);
        send_word(MODE_APPEND, 32'sh7FFF_FFFF);
        send_word(MODE_APPEND, 32'sh7FFF_FFFF);
        send_word(MODE_APPEND, 32'sh0001_0000);
        send_word(MODE_STATS, 0);
        send_word(MODE_LSEARCH, 32'sh7FFF_FFFF);
        send_word(MODE_LSEARCH, 32'sh0000_1234);
        send_word(MODE_BSEARCH, 0);
        send_word(MODE_SORT, 0);
        send_word(MODE_BSEARCH, 32'sh7FFF_FFFF);
        send_word(MODE_BSEARCH, 32'sh8000_0000);
        send_word(MODE_BSEARCH, 32'sh0000_0005);
        send_word(MODE_DEDUP, 0);
        send_word(MODE_APPEND, 32'shFFFF_FFFF);
        send_word(MODE_BSEARCH, 32'shFFFF_FFFF);
        send_word(MODE_STATS, 0);
    endtask

    task automatic test_full();
        while (series_n < N)
            send_word(MODE_APPEND, (series_n % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        send_word(MODE_APPEND, 32'sh1234_5678);
        send_word(MODE_STATS, 0);
        send_word(MODE_SORT, 0);
        send_word(MODE_BSEARCH, 32'sh7FFF_FFFF);
        send_word(MODE_DEDUP, 0);
        drain();
    endtask

    task automatic test_random();
        int unsigned r;
        logic [2:0] mode;
        for (int i = 0; i < 1150; i++)
        begin
            r = $urandom_range(0, 99);
            if (series_n > 24 && r < 55)
                mode = MODE_DEDUP;
            else if (r < 50)
                mode = MODE_APPEND;
            else if (r < 58)
                mode = MODE_STATS;
            else if (r < 70)
                mode = MODE_LSEARCH;
            else if (r < 74)
                mode = MODE_DEDUP;
            else if (r < 80)
                mode = MODE_SORT;
            else if (r < 96)
                mode = MODE_BSEARCH;
            else
                mode = 3'($urandom_range(6, 7));
            if ((mode == MODE_LSEARCH || mode == MODE_BSEARCH) && series_n > 0
                && $urandom_range(0, 1))
                send_word(mode, series_q[$urandom_range(0, series_n - 1)]);
            else
                send_word(mode, pick_value());
            if (i == 600)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        rx_busy_mode = 1'b0;
        series_n = 0;
        sorted_n = 0;
        error_count = 0;
        result_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty();
        test_extremes();
        test_full();
        test_random();
        drain();
        repeat (50) @(negedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("PASS sample_series_stats_search");
        else
            $display("FAIL sample_series_stats_search");
        $finish;
    end

endmodule

>>> sim.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sss_ram.sv
rtl/sss_div.sv
rtl/sample_series_stats_search.sv
rtl/sss_checker.sv
tb/tb_sample_series_stats_search.sv
